@@ rtl/core/sia_pkg.sv @@
// package: command and status codes, widths and stage payload types for the signed alu
package sia_pkg;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned N_DIV_STAGES = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_EQ  = 4'd4,
        CMD_NE  = 4'd5,
        CMD_LT  = 4'd6,
        CMD_LE  = 4'd7,
        CMD_GT  = 4'd8,
        CMD_GE  = 4'd9
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADCMD = 2'd1,
        ST_DIV0   = 2'd2
    } t_status;

    // per-stage side information that does not go through the divider
    typedef struct packed {
        logic                    div_sel;
        logic                    div_neg;
        logic [DATA_W-1:0]       value;
        logic                    is_bool;
        logic [STAT_W-1:0]       status;
    } t_side;
endpackage

@@ rtl/core/sia_if.sv @@
// interface: valid/ready channel carrying an alu command or result
interface sia_cmd_if;
    import sia_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface sia_res_if;
    import sia_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              result_is_bool;
    logic [STAT_W-1:0] status;
    modport source (output valid, result_value, result_is_bool, status, input ready);
    modport sink   (input valid, result_value, result_is_bool, status, output ready);
endinterface

@@ rtl/core/signed_int_alu.sv @@
// top level: pipelined signed 32-bit integer alu
// pipeline: a front stage, DIV_STAGES divider stages and an output stage
// throughput: one transaction per cycle; stalls freeze the whole pipeline
// the divider is DIV_STAGES registered stages of DATA_W / DIV_STAGES steps each
// reset: synchronous active-low i_rst_n clears all stage valid bits
// the final stage holds the result until taken
module signed_int_alu
    import sia_pkg::*;
#(
    parameter int unsigned DIV_STAGES = N_DIV_STAGES
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sia_cmd_if.sink   i_cmd,
    sia_res_if.source o_res
);
    localparam int unsigned STEPS = DATA_W / DIV_STAGES;
    localparam int unsigned NST   = DIV_STAGES + 2;

    logic                 adv;
    logic [NST-1:0]       r_vld;
    t_side                side [NST];
    logic [DATA_W-1:0]    rem  [DIV_STAGES+1];
    logic [DATA_W-1:0]    quo  [DIV_STAGES+1];
    logic [DATA_W-1:0]    dvs  [DIV_STAGES+1];
    t_side                r_side [DIV_STAGES];
    t_side                r_out;
    t_side                n_out;
    logic [DATA_W-1:0]    fin_q;

    assign adv         = !r_vld[NST-1] || o_res.ready;
    assign i_cmd.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_cmd.valid};
        end
    end

    sia_front u_front (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_command   (i_cmd.command),
        .i_operand_a (i_cmd.operand_a),
        .i_operand_b (i_cmd.operand_b),
        .o_side      (side[0]),
        .o_mag_a     (quo[0]),
        .o_mag_b     (dvs[0])
    );
    assign rem[0] = '0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        sia_div_stage #(.STEPS(STEPS)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_rem (rem[g]),
            .i_quo (quo[g]),
            .i_dvs (dvs[g]),
            .o_rem (rem[g+1]),
            .o_quo (quo[g+1]),
            .o_dvs (dvs[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_side[g] <= side[g];
            end
        end
        assign side[g+1] = r_side[g];
    end

    always_comb begin
        fin_q = side[DIV_STAGES].div_neg ? -quo[DIV_STAGES] : quo[DIV_STAGES];
        n_out = side[DIV_STAGES];
        if (side[DIV_STAGES].div_sel) begin
            n_out.value = fin_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end
    assign side[NST-1] = r_out;

    assign o_res.valid          = r_vld[NST-1];
    assign o_res.result_value   = r_out.value;
    assign o_res.result_is_bool = r_out.is_bool;
    assign o_res.status         = r_out.status;
endmodule

@@ rtl/core/sia_div_stage.sv @@
// divider stage: several restoring division steps on an unsigned magnitude
module sia_div_stage
    import sia_pkg::*;
#(
    parameter int unsigned STEPS = 4
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DATA_W-1:0] i_rem,
    input  logic [DATA_W-1:0] i_quo,
    input  logic [DATA_W-1:0] i_dvs,
    output logic [DATA_W-1:0] o_rem,
    output logic [DATA_W-1:0] o_quo,
    output logic [DATA_W-1:0] o_dvs
);
    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] n_quo;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;

    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        trial = '0;
        for (int k = 0; k < STEPS; k++) begin
            trial = {n_rem, n_quo[DATA_W-1]} - {1'b0, i_dvs};
            n_quo = {n_quo[DATA_W-2:0], ~trial[DATA_W]};
            if (!trial[DATA_W]) begin
                n_rem = trial[DATA_W-1:0];
            end else begin
                n_rem = {n_rem[DATA_W-2:0], i_quo[DATA_W-1-k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvs <= i_dvs;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;
endmodule

@@ rtl/core/sia_front.sv @@
// front stage: decode, add/sub, compare, operand magnitudes and the multiply
module sia_front
    import sia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    output t_side             o_side,
    output logic [DATA_W-1:0] o_mag_a,
    output logic [DATA_W-1:0] o_mag_b
);
    t_side             n_side;
    t_side             r_side;
    logic [DATA_W-1:0] r_mag_a;
    logic [DATA_W-1:0] r_mag_b;
    logic              lt;
    logic              gt;
    logic              eq;
    logic [2*DATA_W-1:0] prod;

    assign lt   = $signed(i_operand_a) < $signed(i_operand_b);
    assign gt   = $signed(i_operand_b) < $signed(i_operand_a);
    assign eq   = i_operand_a == i_operand_b;
    assign prod = i_operand_a * i_operand_b;

    always_comb begin
        n_side = '0;
        n_side.status = ST_OK;
        case (t_cmd'(i_command))
            CMD_ADD: n_side.value = i_operand_a + i_operand_b;
            CMD_SUB: n_side.value = i_operand_a - i_operand_b;
            CMD_MUL: n_side.value = prod[DATA_W-1:0];
            CMD_DIV: begin
                if (i_operand_b == '0) begin
                    n_side.status = ST_DIV0;
                end else begin
                    n_side.div_sel = 1'b1;
                    n_side.div_neg = i_operand_a[DATA_W-1] ^ i_operand_b[DATA_W-1];
                end
            end
            CMD_EQ: begin n_side.value = DATA_W'(eq);  n_side.is_bool = 1'b1; end
            CMD_NE: begin n_side.value = DATA_W'(!eq); n_side.is_bool = 1'b1; end
            CMD_LT: begin n_side.value = DATA_W'(lt);  n_side.is_bool = 1'b1; end
            CMD_LE: begin n_side.value = DATA_W'(!gt); n_side.is_bool = 1'b1; end
            CMD_GT: begin n_side.value = DATA_W'(gt);  n_side.is_bool = 1'b1; end
            CMD_GE: begin n_side.value = DATA_W'(!lt); n_side.is_bool = 1'b1; end
            default: n_side.status = ST_BADCMD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= n_side;
            r_mag_a <= i_operand_a[DATA_W-1] ? -i_operand_a : i_operand_a;
            r_mag_b <= i_operand_b[DATA_W-1] ? -i_operand_b : i_operand_b;
        end
    end

    assign o_side  = r_side;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;
endmodule

@@ rtl/core/sia_checker.sv @@
// checker: port-level assertions for the signed alu, bound to the top level
module sia_checker
    import sia_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_value,
    input logic              i_is_bool,
    input logic [STAT_W-1:0] i_status
);
    a_no_out_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("result valid after reset");
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready) else $error("stalled while free");
    a_bool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_is_bool) |-> (i_value[DATA_W-1:1] == '0 && i_status == ST_OK))
        else $error("bad comparison result");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_OK) |-> (i_value == '0 && !i_is_bool))
        else $error("error result not cleared");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_value)))
        else $error("stalled result changed");
endmodule

bind signed_int_alu sia_checker u_sia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_value     (o_res.result_value),
    .i_is_bool   (o_res.result_is_bool),
    .i_status    (o_res.status)
);

@@ verif/alu_checker.sv @@
// checker: watches the command and result channels, predicts alu results and compares them
`timescale 1ns / 100ps
module alu_checker
    import sia_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [3:0]  i_cmd_command,
    input  logic [31:0] i_cmd_a,
    input  logic [31:0] i_cmd_b,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_value,
    input  logic        i_res_is_bool,
    input  logic [1:0]  i_res_status,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] value;
        logic        is_bool;
        logic [1:0]  status;
    } t_alu_result;

    t_alu_result expected_results[$];

    function automatic t_alu_result compute_result(logic [3:0] cmd, logic [31:0] a,
                                                   logic [31:0] b);
        t_alu_result r;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] q;
        sa = a;
        sb = b;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_ADD: r.value = a + b;
            CMD_SUB: r.value = a - b;
            CMD_MUL: r.value = a * b;
            CMD_DIV: begin
                if (b == 32'd0) begin
                    r.status = ST_DIV0;
                end else begin
                    mag_a = a[31] ? -a : a;
                    mag_b = b[31] ? -b : b;
                    q = mag_a / mag_b;
                    r.value = (a[31] != b[31]) ? -q : q;
                end
            end
            CMD_EQ: begin r.value = {31'd0, a == b}; r.is_bool = 1'b1; end
            CMD_NE: begin r.value = {31'd0, a != b}; r.is_bool = 1'b1; end
            CMD_LT: begin r.value = {31'd0, sa < sb}; r.is_bool = 1'b1; end
            CMD_LE: begin r.value = {31'd0, sa <= sb}; r.is_bool = 1'b1; end
            CMD_GT: begin r.value = {31'd0, sa > sb}; r.is_bool = 1'b1; end
            CMD_GE: begin r.value = {31'd0, sa >= sb}; r.is_bool = 1'b1; end
            default: r.status = ST_BADCMD;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alu_result exp_r;
        if (i_rst_n) begin
            if (i_cmd_valid && i_cmd_ready) begin
                expected_results.push_back(compute_result(i_cmd_command, i_cmd_a, i_cmd_b));
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10) begin
                        $display("unexpected result value=%h bool=%b status=%0d",
                                 i_res_value, i_res_is_bool, i_res_status);
                    end
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.value !== i_res_value || exp_r.is_bool !== i_res_is_bool ||
                        exp_r.status !== i_res_status) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10) begin
                            $display("mismatch: expected %h/%b/%0d actual %h/%b/%0d",
                                     exp_r.value, exp_r.is_bool, exp_r.status,
                                     i_res_value, i_res_is_bool, i_res_status);
                        end
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end
endmodule

@@ verif/tb_top.sv @@
// testbench top: drives alu commands with random idling and gives the verdict
`timescale 1ns / 100ps
module tb_top;
    import sia_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;

    sia_cmd_if cmd_ch ();
    sia_res_if res_ch ();

    always #4 i_clk = ~i_clk;

    signed_int_alu u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    alu_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_ch.valid),
        .i_cmd_ready   (cmd_ch.ready),
        .i_cmd_command (cmd_ch.command),
        .i_cmd_a       (cmd_ch.operand_a),
        .i_cmd_b       (cmd_ch.operand_b),
        .i_res_valid   (res_ch.valid),
        .i_res_ready   (res_ch.ready),
        .i_res_value   (res_ch.result_value),
        .i_res_is_bool (res_ch.result_is_bool),
        .i_res_status  (res_ch.status),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.operand_a = '0;
        cmd_ch.operand_b = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return 32'($signed($urandom_range(20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    // ready is sampled at the falling edge, where it already holds its value for the next rise
    task automatic send_cmd(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.operand_a <= a;
        cmd_ch.operand_b <= b;
        @(negedge i_clk);
        while (!cmd_ch.ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] edge_vals[6];
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1, 32'h5555_aaaa};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int c = 0; c < 16; c++) begin
            send_cmd(c[3:0], edge_vals[c % 6], edge_vals[(c + 1) % 6]);
        end
        send_cmd(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_cmd(CMD_DIV, 32'd7, 32'd0);
        send_cmd(CMD_DIV, 32'hffff_fff9, 32'd2);
        send_cmd(CMD_ADD, 32'h7fff_ffff, 32'd1);
        send_cmd(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_cmd(CMD_SUB, 32'h8000_0000, 32'd1);
        send_cmd(CMD_LE, 32'h1234, 32'h1234);
        drain();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 17 : 0;
            for (int n = 0; n < 230; n++) begin
                send_cmd(($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                                  : 4'($urandom_range(9)),
                         pick_operand(), pick_operand());
            end
            drain();
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS signed_int_alu");
        end else begin
            $display("FAIL signed_int_alu");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL signed_int_alu");
        $finish;
    end
endmodule
